// ===== hw/rtl/gtgd_pkg.sv =====
`default_nettype none

package gtgd_pkg;

  // gyro rate word width
  localparam int unsigned RATE_BITS = 16;

  // widths of the fixed fields
  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned THR_BITS    = 15;
  localparam int unsigned MS_BITS     = 16;
  localparam int unsigned ORIENT_BITS = 3;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 16;

  // signed compare width: holds any rate, its magnitude and any threshold
  localparam int unsigned CMP_BITS = ((RATE_BITS > THR_BITS) ? RATE_BITS : THR_BITS) + 2;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_TRIGGER_RATE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_NEUTRAL_RATE = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COOL_GAP_MS  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_POLL_GAP_MS  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SETTLE_MS    = 3'd4;

  // register reset values
  localparam logic [THR_BITS-1:0] TRIGGER_RATE_RST = 15'd1600;
  localparam logic [THR_BITS-1:0] NEUTRAL_RATE_RST = 15'd480;
  localparam logic [MS_BITS-1:0]  COOL_GAP_MS_RST  = 16'd500;
  localparam logic [MS_BITS-1:0]  POLL_GAP_MS_RST  = 16'd50;
  localparam logic [MS_BITS-1:0]  SETTLE_MS_RST    = 16'd100;

  // orientation codes
  localparam logic [ORIENT_BITS-1:0] ORIENT_PORTRAIT  = 3'd0;
  localparam logic [ORIENT_BITS-1:0] ORIENT_INVERTED  = 3'd1;
  localparam logic [ORIENT_BITS-1:0] ORIENT_LAND_CW   = 3'd2;
  localparam logic [ORIENT_BITS-1:0] ORIENT_LAND_CCW  = 3'd3;

  typedef struct packed {
    logic [THR_BITS-1:0] trigger_rate;
    logic [THR_BITS-1:0] neutral_rate;
    logic [MS_BITS-1:0]  cool_gap_ms;
    logic [MS_BITS-1:0]  poll_gap_ms;
    logic [MS_BITS-1:0]  settle_ms;
  } cfg_t;

  typedef struct packed {
    logic forward_event;
    logic back_event;
    logic tilt_held;
    logic is_awake;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gtgd_regs.sv =====
`default_nettype none

module gtgd_regs
  import gtgd_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output cfg_t                          cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_rate <= TRIGGER_RATE_RST;
      cfg_q.neutral_rate <= NEUTRAL_RATE_RST;
      cfg_q.cool_gap_ms  <= COOL_GAP_MS_RST;
      cfg_q.poll_gap_ms  <= POLL_GAP_MS_RST;
      cfg_q.settle_ms    <= SETTLE_MS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TRIGGER_RATE: cfg_q.trigger_rate <= cfg_data_i[THR_BITS-1:0];
        REG_NEUTRAL_RATE: cfg_q.neutral_rate <= cfg_data_i[THR_BITS-1:0];
        REG_COOL_GAP_MS:  cfg_q.cool_gap_ms  <= cfg_data_i[MS_BITS-1:0];
        REG_POLL_GAP_MS:  cfg_q.poll_gap_ms  <= cfg_data_i[MS_BITS-1:0];
        REG_SETTLE_MS:    cfg_q.settle_ms    <= cfg_data_i[MS_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/gtgd_axis.sv =====
`default_nettype none

module gtgd_axis
  import gtgd_pkg::*;
(
  input  wire logic [ORIENT_BITS-1:0]    orientation_i,
  input  wire logic                      invert_direction_i,
  input  wire logic signed [RATE_BITS-1:0] rate_x_i,
  input  wire logic signed [RATE_BITS-1:0] rate_y_i,
  output logic signed [RATE_BITS-1:0]    axis_o
);

  localparam logic signed [RATE_BITS-1:0] RATE_MIN = {1'b1, {(RATE_BITS-1){1'b0}}};
  localparam logic signed [RATE_BITS-1:0] RATE_MAX = {1'b0, {(RATE_BITS-1){1'b1}}};

  logic signed [RATE_BITS-1:0] neg_x;
  logic signed [RATE_BITS-1:0] neg_y;

  // negation saturates at the most negative rate
  assign neg_x = (rate_x_i == RATE_MIN) ? RATE_MAX : -rate_x_i;
  assign neg_y = (rate_y_i == RATE_MIN) ? RATE_MAX : -rate_y_i;

  always_comb begin
    case (orientation_i)
      ORIENT_PORTRAIT: axis_o = invert_direction_i ? neg_x : rate_x_i;
      ORIENT_INVERTED: axis_o = invert_direction_i ? rate_x_i : neg_x;
      ORIENT_LAND_CW:  axis_o = invert_direction_i ? rate_y_i : neg_y;
      ORIENT_LAND_CCW: axis_o = invert_direction_i ? neg_y : rate_y_i;
      default:         axis_o = rate_x_i;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gtgd_core.sv =====
`default_nettype none

module gtgd_core
  import gtgd_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        load_i,
  input  wire cfg_t                        cfg_i,
  input  wire logic [TIME_BITS-1:0]        now_ms_i,
  input  wire logic                        awake_request_i,
  input  wire logic signed [RATE_BITS-1:0] axis_i,
  output res_t                             res_o
);

  logic                 awake_q, awake_d;
  logic                 hold_q, hold_d;
  logic [TIME_BITS-1:0] wake_time_q, wake_time_d;
  logic [TIME_BITS-1:0] poll_time_q, poll_time_d;
  logic [TIME_BITS-1:0] trig_time_q, trig_time_d;
  res_t                 res_q, res_d;

  logic [TIME_BITS-1:0] since_wake, since_poll, since_trig;
  logic                 settled, poll_due, cool_done;
  logic signed [CMP_BITS-1:0] axis_ext, mag, trig_pos, trig_neg, neutral;
  logic                 fwd, back;

  assign since_wake = now_ms_i - wake_time_q;
  assign since_poll = now_ms_i - poll_time_q;
  assign since_trig = now_ms_i - trig_time_q;
  assign settled    = since_wake >= {{(TIME_BITS-MS_BITS){1'b0}}, cfg_i.settle_ms};
  assign poll_due   = since_poll >= {{(TIME_BITS-MS_BITS){1'b0}}, cfg_i.poll_gap_ms};
  assign cool_done  = since_trig >= {{(TIME_BITS-MS_BITS){1'b0}}, cfg_i.cool_gap_ms};

  assign axis_ext = {{(CMP_BITS-RATE_BITS){axis_i[RATE_BITS-1]}}, axis_i};
  assign mag      = axis_ext[CMP_BITS-1] ? -axis_ext : axis_ext;
  assign trig_pos = {{(CMP_BITS-THR_BITS){1'b0}}, cfg_i.trigger_rate};
  assign trig_neg = -trig_pos;
  assign neutral  = {{(CMP_BITS-THR_BITS){1'b0}}, cfg_i.neutral_rate};

  always_comb begin
    awake_d     = awake_q;
    hold_d      = hold_q;
    wake_time_d = wake_time_q;
    poll_time_d = poll_time_q;
    trig_time_d = trig_time_q;
    fwd         = 1'b0;
    back        = 1'b0;
    if (awake_request_i && !awake_q) begin
      // wake item: not evaluated
      awake_d     = 1'b1;
      wake_time_d = now_ms_i;
      poll_time_d = now_ms_i;
      trig_time_d = now_ms_i;
    end else if (!awake_request_i && awake_q) begin
      awake_d = 1'b0;
      hold_d  = 1'b0;
    end else if (awake_request_i && settled && poll_due) begin
      poll_time_d = now_ms_i;
      if (hold_q) begin
        if (mag < neutral) begin
          hold_d = 1'b0;
        end
      end else if (cool_done) begin
        if (axis_ext > trig_pos) begin
          fwd         = 1'b1;
          hold_d      = 1'b1;
          trig_time_d = now_ms_i;
        end else if (axis_ext < trig_neg) begin
          back        = 1'b1;
          hold_d      = 1'b1;
          trig_time_d = now_ms_i;
        end
      end
    end
    res_d.forward_event = fwd;
    res_d.back_event    = back;
    res_d.tilt_held     = hold_d;
    res_d.is_awake      = awake_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awake_q     <= 1'b0;
      hold_q      <= 1'b0;
      wake_time_q <= '0;
      poll_time_q <= '0;
      trig_time_q <= '0;
    end else if (load_i) begin
      awake_q     <= awake_d;
      hold_q      <= hold_d;
      wake_time_q <= wake_time_d;
      poll_time_q <= poll_time_d;
      trig_time_q <= trig_time_d;
    end
  end

  // result register, payload only
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/gyro_tilt_gesture_detector_unit.sv =====
`default_nettype none

// channel   valid        stall        payload
// -------   -----------  -----------  ----------------------------------------------
// in        in_valid_i   in_stall_o   now_ms_i awake_request_i orientation_i
//                                     invert_direction_i rate_x_i rate_y_i
// out       out_valid_o  out_stall_i  forward_event_o back_event_o tilt_held_o is_awake_o
// cfg       cfg_we_i     (none)       cfg_idx_i cfg_data_i
//
// one item per cycle sustained while out_stall_i stays low; an accepted item sits in the input
// register, and at the next free edge the decision logic loads its result into the result
// register, where the detector state updates at the same edge
// reset clears the config registers to their defaults, the detector state and both
// valid flags; no clearing pass
// output stall holds the result register; the input register keeps accepting as long
// as it can hand its item on, so one stalled result costs no bubble

module gyro_tilt_gesture_detector_unit
  import gtgd_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // config write port
  input  wire logic                        cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0]    cfg_data_i,
  // input items
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [TIME_BITS-1:0]        now_ms_i,
  input  wire logic                        awake_request_i,
  input  wire logic [ORIENT_BITS-1:0]      orientation_i,
  input  wire logic                        invert_direction_i,
  input  wire logic signed [RATE_BITS-1:0] rate_x_i,
  input  wire logic signed [RATE_BITS-1:0] rate_y_i,
  // result items
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             forward_event_o,
  output logic                             back_event_o,
  output logic                             tilt_held_o,
  output logic                             is_awake_o
);

  cfg_t cfg;
  res_t res;

  // input register
  logic                        in_valid_q;
  logic [TIME_BITS-1:0]        now_q;
  logic                        req_q;
  logic [ORIENT_BITS-1:0]      orient_q;
  logic                        inv_q;
  logic signed [RATE_BITS-1:0] rate_x_q;
  logic signed [RATE_BITS-1:0] rate_y_q;

  logic                        out_valid_q;
  logic                        out_ready;
  logic                        in_ready;
  logic                        in_take;
  logic                        load;
  logic signed [RATE_BITS-1:0] axis;

  // handshake: result register frees when empty or taken
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign load       = in_valid_q && out_ready;
  assign in_ready   = !in_valid_q || out_ready;
  assign in_take    = in_valid_i && in_ready;
  assign in_stall_o = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      now_q    <= now_ms_i;
      req_q    <= awake_request_i;
      orient_q <= orientation_i;
      inv_q    <= invert_direction_i;
      rate_x_q <= rate_x_i;
      rate_y_q <= rate_y_i;
    end
  end

  gtgd_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // pick and sign the tilt axis
  gtgd_axis u_axis (
    .orientation_i      (orient_q),
    .invert_direction_i (inv_q),
    .rate_x_i           (rate_x_q),
    .rate_y_i           (rate_y_q),
    .axis_o             (axis)
  );

  // wake/sleep, settle, poll, hysteresis and cooldown
  gtgd_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .cfg_i           (cfg),
    .now_ms_i        (now_q),
    .awake_request_i (req_q),
    .axis_i          (axis),
    .res_o           (res)
  );

  assign out_valid_o     = out_valid_q;
  assign forward_event_o = res.forward_event;
  assign back_event_o    = res.back_event;
  assign tilt_held_o     = res.tilt_held;
  assign is_awake_o      = res.is_awake;

endmodule

`default_nettype wire

// ===== bench/tb_gyro_tilt_gesture_detector_unit.sv =====
module tb_gyro_tilt_gesture_detector_unit;
  import gtgd_pkg::*;

  // cycles with no handshake on either channel before giving up
  localparam int QUIET_LIMIT = 1000;
  // longest idle or stall drawn per item
  localparam int MAX_WAIT = 4;
  // two stages from acceptance to result, plus margin
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_ITEMS = 210;
  localparam int PHASES = 8;
  localparam int PRINT_LIMIT = 100;

  // orientation codes outside the four named ones
  localparam logic [ORIENT_BITS-1:0] ORIENT_OTHER = 3'd4;
  localparam logic [ORIENT_BITS-1:0] ORIENT_LAST = 3'd7;
  // an index with no register behind it
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 3'd7;

  localparam logic signed [RATE_BITS-1:0] RATE_MIN = {1'b1, {(RATE_BITS-1){1'b0}}};
  localparam logic signed [RATE_BITS-1:0] RATE_MAX = {1'b0, {(RATE_BITS-1){1'b1}}};

  // one gyro sample as it crosses the input channel
  typedef struct {
    logic [TIME_BITS-1:0]        now;
    logic                        wake;
    logic [ORIENT_BITS-1:0]      orient;
    logic                        inv;
    logic signed [RATE_BITS-1:0] rx;
    logic signed [RATE_BITS-1:0] ry;
  } sample_t;

  // all inputs known from time zero
  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]     cfg_idx_i = '0;
  logic [CFG_DATA_BITS-1:0]    cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [TIME_BITS-1:0]        now_ms_i = '0;
  logic                        awake_request_i = 1'b0;
  logic [ORIENT_BITS-1:0]      orientation_i = '0;
  logic                        invert_direction_i = 1'b0;
  logic signed [RATE_BITS-1:0] rate_x_i = '0;
  logic signed [RATE_BITS-1:0] rate_y_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic                        forward_event_o;
  logic                        back_event_o;
  logic                        tilt_held_o;
  logic                        is_awake_o;

  gyro_tilt_gesture_detector_unit uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // detector state as the predictor sees it
  logic                 awake_st;
  logic                 hold_st;
  logic [TIME_BITS-1:0] wake_ms;
  logic [TIME_BITS-1:0] poll_ms;
  logic [TIME_BITS-1:0] trig_ms;
  cfg_t                 shadow;

  sample_t sample_q[$];   // samples waiting for the driver
  res_t    verdict_q[$];  // predicted results, oldest first
  int      fault_count = 0;
  bit      no_idle = 1'b0; // both sides run flat out

  task automatic log_fault(input string msg);
    if (fault_count < PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
    fault_count++;
  endtask

  task automatic check_flag(input string field, input logic want, input logic got);
    if (got !== want) log_fault($sformatf("%s expected %0b got %0b", field, want, got));
  endtask

  // negation that clips the most negative rate to the largest positive one
  function automatic logic signed [RATE_BITS-1:0] flip_rate(
    input logic signed [RATE_BITS-1:0] v
  );
    if (v == RATE_MIN) return RATE_MAX;
    return -v;
  endfunction

  // advance the detector by one sample and return the result it shows
  function automatic res_t tilt_decide(input sample_t s);
    res_t                        r;
    logic signed [RATE_BITS-1:0] axis;
    logic [TIME_BITS-1:0]        since_wake;
    logic [TIME_BITS-1:0]        since_poll;
    logic [TIME_BITS-1:0]        since_trig;
    int                          a;
    int                          mag;
    int                          thr;
    int                          neu;
    r = '0;
    since_wake = s.now - wake_ms;
    since_poll = s.now - poll_ms;
    since_trig = s.now - trig_ms;
    thr = shadow.trigger_rate;
    neu = shadow.neutral_rate;
    if (s.wake && !awake_st) begin
      // wake: stamp all three times, no evaluation
      awake_st = 1'b1;
      wake_ms = s.now;
      poll_ms = s.now;
      trig_ms = s.now;
    end else if (!s.wake && awake_st) begin
      awake_st = 1'b0;
      hold_st = 1'b0;
    end else if (s.wake && since_wake >= shadow.settle_ms
                 && since_poll >= shadow.poll_gap_ms) begin
      poll_ms = s.now;
      case (s.orient)
        ORIENT_PORTRAIT: axis = s.inv ? flip_rate(s.rx) : s.rx;
        ORIENT_INVERTED: axis = s.inv ? s.rx : flip_rate(s.rx);
        ORIENT_LAND_CW:  axis = s.inv ? s.ry : flip_rate(s.ry);
        ORIENT_LAND_CCW: axis = s.inv ? flip_rate(s.ry) : s.ry;
        default:         axis = s.rx;
      endcase
      a = axis;
      if (hold_st) begin
        mag = (a < 0) ? -a : a;
        if (mag < neu) hold_st = 1'b0;
      end else if (since_trig >= shadow.cool_gap_ms) begin
        if (a > thr) begin
          r.forward_event = 1'b1;
          hold_st = 1'b1;
          trig_ms = s.now;
        end else if (a < -thr) begin
          r.back_event = 1'b1;
          hold_st = 1'b1;
          trig_ms = s.now;
        end
      end
    end
    r.tilt_held = hold_st;
    r.is_awake = awake_st;
    return r;
  endfunction

  // rates clustered around the live thresholds, plus extremes and noise
  function automatic logic signed [RATE_BITS-1:0] pick_rate();
    int m;
    int roll;
    roll = $urandom_range(0, 9);
    if (roll >= 7) return RATE_BITS'($urandom);
    case (roll)
      0, 1, 2: m = int'(shadow.trigger_rate) + int'($urandom_range(0, 6)) - 3;
      3, 4:    m = int'(shadow.neutral_rate) + int'($urandom_range(0, 6)) - 3;
      5:       m = $urandom_range(0, 64);
      default: m = 32768;
    endcase
    if (m < 0) m = 0;
    if ($urandom_range(0, 1)) m = -m;
    if (m > int'(RATE_MAX)) m = RATE_MAX;
    return m[RATE_BITS-1:0];
  endfunction

  function automatic void add_sample(
    input logic [TIME_BITS-1:0] now, input logic wake, input logic [ORIENT_BITS-1:0] orient,
    input logic inv, input logic signed [RATE_BITS-1:0] rx,
    input logic signed [RATE_BITS-1:0] ry
  );
    sample_t s;
    s.now = now;
    s.wake = wake;
    s.orient = orient;
    s.inv = inv;
    s.rx = rx;
    s.ry = ry;
    sample_q.push_back(s);
  endfunction

  // a phase of mostly well-formed awake sessions with random timing and rates
  task automatic build_phase(input int count);
    logic [TIME_BITS-1:0]   clock_ms;
    logic                   req;
    logic                   inv;
    logic [ORIENT_BITS-1:0] orient;
    int                     roll;
    int                     span;
    clock_ms = $urandom;
    req = 1'b1;
    orient = ORIENT_BITS'($urandom_range(0, 3));
    inv = 1'($urandom_range(0, 1));
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        // noise: any time, any request, any orientation
        clock_ms = $urandom;
        req = 1'($urandom_range(0, 1));
        orient = ORIENT_BITS'($urandom);
        inv = 1'($urandom_range(0, 1));
        add_sample(clock_ms, req, orient, inv, RATE_BITS'($urandom), RATE_BITS'($urandom));
      end else begin
        // short sleeps, then back awake on the next sample
        req = (roll < 12) ? ~req : 1'b1;
        roll = $urandom_range(0, 9);
        if (roll < 6) span = 2 * shadow.poll_gap_ms + 2;
        else if (roll < 9)
          span = shadow.settle_ms + shadow.cool_gap_ms + shadow.poll_gap_ms + 2;
        else span = 3;
        clock_ms += $urandom_range(0, span);
        if ($urandom_range(0, 19) == 0) begin
          orient = ORIENT_BITS'($urandom);
          inv = 1'($urandom_range(0, 1));
        end
        add_sample(clock_ms, req, orient, inv, pick_rate(), pick_rate());
      end
    end
  endtask

  task automatic load_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_TRIGGER_RATE: shadow.trigger_rate = data[THR_BITS-1:0];
      REG_NEUTRAL_RATE: shadow.neutral_rate = data[THR_BITS-1:0];
      REG_COOL_GAP_MS:  shadow.cool_gap_ms = data;
      REG_POLL_GAP_MS:  shadow.poll_gap_ms = data;
      REG_SETTLE_MS:    shadow.settle_ms = data;
      default: ;
    endcase
  endtask

  // back-to-back writes of every register, and one to an unused index
  task automatic apply_settings(
    input logic [15:0] trig, input logic [15:0] neut, input logic [15:0] cool,
    input logic [15:0] poll, input logic [15:0] settle
  );
    load_reg(REG_TRIGGER_RATE, trig);
    load_reg(REG_NEUTRAL_RATE, neut);
    load_reg(REG_COOL_GAP_MS, cool);
    load_reg(REG_POLL_GAP_MS, poll);
    load_reg(REG_SETTLE_MS, settle);
    load_reg(REG_SPARE, 16'($urandom));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every sample is sent and every predicted result is back, then let the pipe empty
  task automatic drain_all();
    while (sample_q.size() != 0 || in_valid_i || verdict_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // driver: one sample per handshake, random idle after each
  sample_t cur;
  int      gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) verdict_q.push_back(tilt_decide(cur));
      // a stalled sample stays put
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (sample_q.size() != 0) begin
          cur = sample_q.pop_front();
          now_ms_i <= cur.now;
          awake_request_i <= cur.wake;
          orientation_i <= cur.orient;
          invert_direction_i <= cur.inv;
          rate_x_i <= cur.rx;
          rate_y_i <= cur.ry;
          in_valid_i <= 1'b1;
          gap_left = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result, then stall for a random stretch
  int   stall_left = 0;
  res_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          log_fault("result with no prediction pending");
        end else begin
          want = verdict_q.pop_front();
          check_flag("forward_event", want.forward_event, forward_event_o);
          check_flag("back_event", want.back_event, back_event_o);
          check_flag("tilt_held", want.tilt_held, tilt_held_o);
          check_flag("is_awake", want.is_awake, is_awake_o);
        end
        stall_left = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on handshake activity
  int quiet = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int          ph;
    logic [15:0] t;
    awake_st = 1'b0;
    hold_st = 1'b0;
    wake_ms = '0;
    poll_ms = '0;
    trig_ms = '0;
    shadow.trigger_rate = TRIGGER_RATE_RST;
    shadow.neutral_rate = NEUTRAL_RATE_RST;
    shadow.cool_gap_ms = COOL_GAP_MS_RST;
    shadow.poll_gap_ms = POLL_GAP_MS_RST;
    shadow.settle_ms = SETTLE_MS_RST;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed walk through the reset settings
    // asleep sample is ignored
    add_sample(32'd10, 1'b0, ORIENT_PORTRAIT, 1'b0, RATE_MAX, RATE_MIN);
    add_sample(32'd1000, 1'b1, ORIENT_PORTRAIT, 1'b0, 0, 0);
    // still settling
    add_sample(32'd1050, 1'b1, ORIENT_PORTRAIT, 1'b0, RATE_MAX, 0);
    // cooldown from wake not over yet
    add_sample(32'd1100, 1'b1, ORIENT_PORTRAIT, 1'b0, 2000, 0);
    add_sample(32'd1500, 1'b1, ORIENT_PORTRAIT, 1'b0, 1601, 0);
    // too soon after the last poll
    add_sample(32'd1520, 1'b1, ORIENT_PORTRAIT, 1'b0, 0, 0);
    // exactly at neutral keeps the hold
    add_sample(32'd1550, 1'b1, ORIENT_PORTRAIT, 1'b0, 480, 0);
    add_sample(32'd1600, 1'b1, ORIENT_PORTRAIT, 1'b0, -479, 0);
    // negating the most negative rate clips
    add_sample(32'd2000, 1'b1, ORIENT_PORTRAIT, 1'b1, RATE_MIN, 0);
    add_sample(32'd2050, 1'b1, ORIENT_INVERTED, 1'b0, 0, 0);
    // exactly at trigger does not fire
    add_sample(32'd2600, 1'b1, ORIENT_INVERTED, 1'b0, 1600, 0);
    add_sample(32'd2650, 1'b1, ORIENT_INVERTED, 1'b0, 1601, 0);
    add_sample(32'd2700, 1'b1, ORIENT_INVERTED, 1'b1, 0, 0);
    add_sample(32'd3200, 1'b1, ORIENT_LAND_CW, 1'b0, 0, -2000);
    add_sample(32'd3250, 1'b1, ORIENT_LAND_CW, 1'b1, 0, 100);
    add_sample(32'd3800, 1'b1, ORIENT_LAND_CW, 1'b1, 0, -2000);
    // sleep while held clears the hold
    add_sample(32'd3850, 1'b0, ORIENT_LAND_CW, 1'b1, 0, -2000);
    add_sample(32'd3900, 1'b1, ORIENT_LAND_CCW, 1'b0, 0, 0);
    add_sample(32'd4400, 1'b1, ORIENT_LAND_CCW, 1'b0, 0, RATE_MIN);
    add_sample(32'd4450, 1'b1, ORIENT_LAND_CCW, 1'b1, 0, RATE_MIN);
    // other codes take rate_x as is, invert ignored
    add_sample(32'd4500, 1'b1, ORIENT_OTHER, 1'b1, 0, 0);
    add_sample(32'd5000, 1'b1, ORIENT_LAST, 1'b1, -2000, RATE_MAX);
    // time wraps past zero
    add_sample(32'hFFFF_FFF0, 1'b1, ORIENT_PORTRAIT, 1'b0, 0, 0);
    add_sample(32'h0000_0200, 1'b1, ORIENT_PORTRAIT, 1'b0, 1601, 0);
    add_sample(32'h0000_0210, 1'b0, ORIENT_PORTRAIT, 1'b0, 0, 0);
    drain_all();

    // random phases, each under its own settings
    for (ph = 0; ph < PHASES; ph++) begin
      t = 16'($urandom_range(0, 4000));
      case (ph)
        0: apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        // thresholds beyond 15 bits drop the top bit
        1: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: apply_settings(16'd1600, 16'd480, 16'd500, 16'd50, 16'd100);
        3: apply_settings(16'd200, 16'd100, 16'd0, 16'd0, 16'd0);
        // neutral above trigger
        6: apply_settings(16'd100, 16'd5000, 16'd30, 16'd10, 16'd20);
        default: apply_settings(t, 16'($urandom_range(0, t + 200)),
                                16'($urandom_range(0, 400)),
                                16'($urandom_range(0, 400)),
                                16'($urandom_range(0, 400)));
      endcase
      @(negedge clk_i);
      no_idle = (ph == 2 || ph == 5);
      build_phase(PHASE_ITEMS);
      drain_all();
    end

    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/gtgd_pkg.sv
hw/rtl/gtgd_regs.sv
hw/rtl/gtgd_axis.sv
hw/rtl/gtgd_core.sv
hw/rtl/gyro_tilt_gesture_detector_unit.sv
bench/tb_gyro_tilt_gesture_detector_unit.sv
